// ===== sv/pnes_pkg.sv =====
package pnes_pkg;

  localparam int MAX_ROWS_DEF = 256;
  localparam int MAX_COLS_DEF = 64;
  localparam int VALUE_BITS_DEF = 32;

  localparam int ACC_BITS = 48;

  localparam logic [1:0] ACT_LOAD_A = 2'd0;
  localparam logic [1:0] ACT_LOAD_B = 2'd1;
  localparam logic [1:0] ACT_LOAD_X = 2'd2;
  localparam logic [1:0] ACT_RUN = 2'd3;

  localparam logic [1:0] REG_ITER_LIMIT = 2'd0;
  localparam logic [1:0] REG_STOP_THRESH = 2'd1;
  localparam logic [1:0] REG_ROWS = 2'd2;
  localparam logic [1:0] REG_COLS = 2'd3;

  localparam logic [15:0] ITER_LIMIT_RESET = 16'd100;
  localparam logic [8:0] ROWS_RESET = 9'd256;
  localparam logic [6:0] COLS_RESET = 7'd64;

  localparam logic [47:0] ACC_MAX = {48{1'b1}};
  localparam logic [31:0] BOUND_MAX = 32'hFFFF_FFFF;

  // saturating add on 48-bit accumulators
  function automatic logic [47:0] add_sat48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? ACC_MAX : s[47:0];
  endfunction

endpackage

// ===== sv/pnes_divider.sv =====
module pnes_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [47:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic        busy;
  logic [6:0]  count;
  logic [63:0] quo;
  logic [48:0] rem;
  logic [47:0] dvs;
  logic [49:0] trial;

  assign trial = {rem, quo[63]} - {2'b00, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 7'd64;
        quo <= dividend;
        rem <= '0;
        dvs <= divisor;
      end else if (busy) begin
        if (!trial[49]) begin
          rem <= trial[48:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[47:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        count <= count - 7'd1;
        if (count == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/poisson_nnls_em_solver_unit.sv =====
// Poisson ML-EM solver with one shared multiplier and one shared divider.
// Input channel (in_valid/in_ready) takes load transactions and run transactions.
// A load (matrix entry, observation, initial estimate) leaves the block idle,
// so loads stream back to back; out-of-range loads are dropped and
// loads give no result.
// A run transaction iterates up to iteration_limit times over all m rows and
// n columns, then emits n result transactions on out_valid/out_ready, one per
// unknown, last_item marking unknown n-1.
// Run time is set by the 3-pass 48x16 multiplier and the bit-serial divider,
// the divider used at most once per row and twice per unknown.
// Results then leave one at a time, each read from the estimate store first.
// in_ready is low for the whole run, including while results drain.
// A stalled receiver holds the current result; the block waits.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; the user
// must make them only while the block is idle, as the block does not enforce it.
// Reset (rst, synchronous) returns the registers to their reset values and the
// sequencer to idle; the sums are cleared at the start of every iteration and
// the matrix, observation and estimate stores need no clearing pass.
module poisson_nnls_em_solver_unit #(
  parameter int MAX_ROWS = pnes_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = pnes_pkg::MAX_COLS_DEF,
  parameter int VALUE_BITS = pnes_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  row_index,
  input  logic [5:0]  col_index,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_index,
  output logic [31:0] estimate,
  output logic [15:0] iterations_done,
  output logic        last_item
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CCW = $clog2(MAX_COLS + 1);
  localparam logic [47:0] VMAX = 48'((64'd1 << VALUE_BITS) - 64'd1);
  localparam logic [47:0] ACC_MAX_L = pnes_pkg::ACC_MAX;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_ITER   = 5'd1;
  localparam logic [4:0] S_CLR    = 5'd2;
  localparam logic [4:0] S_RRD    = 5'd3;
  localparam logic [4:0] S_RMUL   = 5'd4;
  localparam logic [4:0] S_RACC   = 5'd5;
  localparam logic [4:0] S_RDIV   = 5'd6;
  localparam logic [4:0] S_RDIVW  = 5'd7;
  localparam logic [4:0] S_NMUL   = 5'd8;
  localparam logic [4:0] S_NACC   = 5'd9;
  localparam logic [4:0] S_URD    = 5'd10;
  localparam logic [4:0] S_UMUL   = 5'd11;
  localparam logic [4:0] S_UDIV1  = 5'd12;
  localparam logic [4:0] S_UDIV1W = 5'd13;
  localparam logic [4:0] S_UBMUL  = 5'd14;
  localparam logic [4:0] S_UDIV2  = 5'd15;
  localparam logic [4:0] S_UDIV2W = 5'd16;
  localparam logic [4:0] S_UNEXT  = 5'd17;
  localparam logic [4:0] S_CHECK  = 5'd18;
  localparam logic [4:0] S_ORD    = 5'd19;
  localparam logic [4:0] S_OUT    = 5'd20;

  logic [15:0] iter_limit;
  logic [31:0] stop_thresh;
  logic [8:0]  rows_cfg;
  logic [6:0]  cols_cfg;

  logic [VALUE_BITS-1:0] amem [MAX_ROWS*MAX_COLS];
  logic [VALUE_BITS-1:0] bmem [MAX_ROWS];
  logic [VALUE_BITS-1:0] xmem [MAX_COLS];
  logic [47:0] num_s [MAX_COLS];
  logic [47:0] den_s [MAX_COLS];
  logic [47:0] pred [MAX_COLS];

  logic [4:0]  state;
  logic [RCW-1:0] m_cnt;
  logic [CCW-1:0] n_cnt;
  logic [RW-1:0] row;
  logic [CW-1:0] col;
  logic [15:0] iter;
  logic [VALUE_BITS-1:0] a_q, b_q, x_q;
  logic [47:0] lam, coe, dx, dd, num_q, den_q;
  logic [31:0] bound;
  logic [47:0] mul_a, mul_b;
  logic [47:0] mul_cap;
  logic [95:0] prod;
  logic [47:0] mul_res;
  logic        mul_go, mul_done;
  logic [1:0]  mul_cnt;
  logic [47:0] mul_bsh;
  logic [63:0] mul_part;

  logic        div_start, div_done;
  logic [63:0] div_n, div_q;
  logic [47:0] div_d;

  logic [RCW-1:0] m_eff;
  logic [CCW-1:0] n_eff;

  always_comb begin
    if (rows_cfg == 9'd0) m_eff = RCW'(1);
    else if (32'(rows_cfg) > MAX_ROWS) m_eff = RCW'(MAX_ROWS);
    else m_eff = RCW'(rows_cfg);
    if (cols_cfg == 7'd0) n_eff = CCW'(1);
    else if (32'(cols_cfg) > MAX_COLS) n_eff = CCW'(MAX_COLS);
    else n_eff = CCW'(cols_cfg);
  end

  // shared multiplier: three 48x16 passes, top slice first
  assign mul_part = 64'(mul_a) * 64'(mul_bsh[47:32]);

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_cnt <= '0;
      mul_done <= 1'b0;
    end else begin
      mul_done <= 1'b0;
      if (mul_go) begin
        mul_cnt <= 2'd3;
        mul_bsh <= mul_b;
        prod <= '0;
      end else if (mul_cnt != 2'd0) begin
        prod <= {prod[79:0], 16'd0} + 96'(mul_part);
        mul_bsh <= {mul_bsh[31:0], 16'd0};
        mul_cnt <= mul_cnt - 2'd1;
        if (mul_cnt == 2'd1) mul_done <= 1'b1;
      end
    end
  end

  // floor(a*b/2^16) saturated to cap
  always_comb begin
    if (prod[95:64] != 32'd0 || prod[63:16] > mul_cap) mul_res = mul_cap;
    else mul_res = prod[63:16];
  end

  pnes_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_n), .divisor(div_d),
    .done(div_done), .quotient(div_q)
  );

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  logic [31:0] vin;
  assign vin = (VALUE_BITS < 32 && value > 32'(VMAX)) ? 32'(VMAX) : value;

  logic [47:0] dq_sat;
  assign dq_sat = (div_q[63:48] != 16'd0) ? ACC_MAX_L : div_q[47:0];

  logic [CCW-1:0] col_ext;
  assign col_ext = CCW'(col);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      iter_limit <= pnes_pkg::ITER_LIMIT_RESET;
      stop_thresh <= '0;
      rows_cfg <= pnes_pkg::ROWS_RESET;
      cols_cfg <= pnes_pkg::COLS_RESET;
      div_start <= 1'b0;
      mul_go <= 1'b0;
    end else begin
      div_start <= 1'b0;
      mul_go <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          pnes_pkg::REG_ITER_LIMIT:  iter_limit <= cfg_data[15:0];
          pnes_pkg::REG_STOP_THRESH: stop_thresh <= cfg_data;
          pnes_pkg::REG_ROWS:        rows_cfg <= cfg_data[8:0];
          pnes_pkg::REG_COLS:        cols_cfg <= cfg_data[6:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (action)
              pnes_pkg::ACT_LOAD_A:
                if (32'(row_index) < MAX_ROWS && 32'(col_index) < MAX_COLS)
                  amem[AW'(row_index) * AW'(MAX_COLS) + AW'(col_index)] <=
                    VALUE_BITS'(vin);
              pnes_pkg::ACT_LOAD_B:
                if (32'(row_index) < MAX_ROWS) bmem[RW'(row_index)] <= VALUE_BITS'(vin);
              pnes_pkg::ACT_LOAD_X:
                if (32'(col_index) < MAX_COLS) xmem[CW'(col_index)] <= VALUE_BITS'(vin);
              default: begin
                m_cnt <= m_eff;
                n_cnt <= n_eff;
                iter <= '0;
                state <= S_ITER;
              end
            endcase
          end
        end
        S_ITER: begin
          if (iter < iter_limit) begin
            col <= '0;
            state <= S_CLR;
          end else begin
            col <= '0;
            state <= S_ORD;
          end
        end
        S_CLR: begin
          num_s[col] <= '0;
          den_s[col] <= '0;
          if (col_ext == n_cnt - CCW'(1)) begin
            col <= '0;
            row <= '0;
            lam <= '0;
            state <= S_RRD;
          end else col <= col + CW'(1);
        end
        S_RRD: begin
          a_q <= amem[AW'(row) * AW'(MAX_COLS) + AW'(col)];
          x_q <= xmem[col];
          b_q <= bmem[row];
          den_q <= den_s[col];
          state <= S_RMUL;
        end
        S_RMUL: begin
          mul_a <= 48'(a_q);
          mul_b <= 48'(x_q);
          mul_cap <= ACC_MAX_L;
          mul_go <= 1'b1;
          state <= S_RACC;
        end
        S_RACC: begin
          if (mul_done) begin
            pred[col] <= mul_res;
            lam <= pnes_pkg::add_sat48(lam, mul_res);
            den_s[col] <= pnes_pkg::add_sat48(den_q, 48'(a_q));
            if (col_ext == n_cnt - CCW'(1)) begin
              col <= '0;
              state <= S_RDIV;
            end else begin
              col <= col + CW'(1);
              state <= S_RRD;
            end
          end
        end
        S_RDIV: begin
          if (b_q != '0 && lam != '0) begin
            div_n <= {16'd0, 48'(b_q)} << 16;
            div_d <= lam;
            div_start <= 1'b1;
            state <= S_RDIVW;
          end else begin
            coe <= '0;
            state <= S_NMUL;
          end
        end
        S_RDIVW: begin
          if (div_done) begin
            coe <= dq_sat;
            state <= S_NMUL;
          end
        end
        S_NMUL: begin
          mul_a <= coe;
          mul_b <= pred[col];
          mul_cap <= ACC_MAX_L;
          mul_go <= 1'b1;
          num_q <= num_s[col];
          state <= S_NACC;
        end
        S_NACC: begin
          if (mul_done) begin
            num_s[col] <= pnes_pkg::add_sat48(num_q, mul_res);
            if (col_ext == n_cnt - CCW'(1)) begin
              col <= '0;
              if (32'(row) + 1 == 32'(m_cnt)) begin
                bound <= '0;
                state <= S_URD;
              end else begin
                row <= row + RW'(1);
                lam <= '0;
                state <= S_RRD;
              end
            end else begin
              col <= col + CW'(1);
              state <= S_NMUL;
            end
          end
        end
        S_URD: begin
          num_q <= num_s[col];
          den_q <= den_s[col];
          x_q <= xmem[col];
          mul_a <= den_s[col];
          mul_b <= 48'(xmem[col]);
          mul_cap <= ACC_MAX_L;
          mul_go <= 1'b1;
          state <= S_UMUL;
        end
        S_UMUL: begin
          if (mul_done) begin
            if (num_q == '0) begin
              xmem[col] <= '0;
              state <= S_UNEXT;
            end else begin
              dx <= mul_res;
              dd <= (num_q > mul_res) ? num_q - mul_res : mul_res - num_q;
              if (mul_res == '0) begin
                bound <= pnes_pkg::BOUND_MAX;
                state <= S_UDIV2;
              end else state <= S_UDIV1;
            end
          end
        end
        S_UDIV1: begin
          div_n <= {dd, 16'd0};
          div_d <= dx;
          div_start <= 1'b1;
          state <= S_UDIV1W;
        end
        S_UDIV1W: begin
          if (div_done) begin
            mul_a <= dd;
            mul_b <= dq_sat;
            mul_cap <= 48'(pnes_pkg::BOUND_MAX);
            mul_go <= 1'b1;
            state <= S_UBMUL;
          end
        end
        S_UBMUL: begin
          if (mul_done) begin
            bound <= ({16'd0, bound} + mul_res > 48'(pnes_pkg::BOUND_MAX)) ?
                     pnes_pkg::BOUND_MAX : 32'({16'd0, bound} + mul_res);
            state <= S_UDIV2;
          end
        end
        S_UDIV2: begin
          if (den_q == '0) begin
            xmem[col] <= VALUE_BITS'(VMAX);
            state <= S_UNEXT;
          end else begin
            div_n <= {num_q, 16'd0};
            div_d <= den_q;
            div_start <= 1'b1;
            state <= S_UDIV2W;
          end
        end
        S_UDIV2W: begin
          if (div_done) begin
            xmem[col] <= (div_q > 64'(VMAX)) ? VALUE_BITS'(VMAX) : VALUE_BITS'(div_q);
            state <= S_UNEXT;
          end
        end
        S_UNEXT: begin
          if (col_ext == n_cnt - CCW'(1)) begin
            col <= '0;
            iter <= iter + 16'd1;
            state <= S_CHECK;
          end else begin
            col <= col + CW'(1);
            state <= S_URD;
          end
        end
        S_CHECK: begin
          if (bound <= stop_thresh) state <= S_ORD;
          else state <= S_ITER;
        end
        S_ORD: begin
          x_q <= xmem[col];
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            if (col_ext == n_cnt - CCW'(1)) state <= S_IDLE;
            else begin
              col <= col + CW'(1);
              state <= S_ORD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_index = 6'(col);
  assign estimate = (48'(x_q) > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(x_q);
  assign iterations_done = iter;
  assign last_item = (col_ext == n_cnt - CCW'(1));

endmodule
